>>> design/rmq_pkg.sv
// shared types and constants for the rotation matrix to quaternion core
// no dependencies; used by the channel interfaces and the core
package rmq_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int ELEM_W        = 16;
	localparam int QMAX          = 32767;

	typedef logic signed [ELEM_W-1:0] elem_t;

	// which diagonal term drives the square root
	typedef enum logic [1:0] {
		BR_TRACE,
		BR_X,
		BR_Y,
		BR_Z
	} branch_t;

endpackage

>>> design/rmq_mat_if.sv
// matrix request channel: valid/ready handshake carrying nine Q2.14 elements
// depends on rmq_pkg
interface rmq_mat_if;
	logic              valid;
	logic              ready;
	rmq_pkg::elem_t    r00, r01, r02;
	rmq_pkg::elem_t    r10, r11, r12;
	rmq_pkg::elem_t    r20, r21, r22;

	modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, input ready);
	modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, output ready);
endinterface

>>> design/rmq_quat_if.sv
// quaternion result channel: valid/ready handshake carrying w, x, y, z
// depends on rmq_pkg
interface rmq_quat_if;
	logic              valid;
	logic              ready;
	rmq_pkg::elem_t    quat_w, quat_x, quat_y, quat_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

>>> design/rotation_matrix_to_quaternion_core.sv
// Rotation matrix to quaternion core (four-branch method), fully pipelined.
// One matrix request is taken every cycle while the pipe is not stalled; each
// gives one quaternion. The square root is bit-serial, one root bit per stage,
// followed by three restoring dividers working side by side. The whole pipe
// stalls together while the result register is held.
// depends on rmq_pkg, rmq_mat_if, rmq_quat_if
module rotation_matrix_to_quaternion_core #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rmq_mat_if.sink     mat,
	rmq_quat_if.source  quat
);

	localparam int AW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
	localparam int SW = AW + FRAC_BITS;
	localparam int RW = (SW + 1) / 2;
	localparam int XW = 2 * RW;
	localparam int RM = RW + 3;
	localparam int DV = RW + 1;
	localparam int NW = rmq_pkg::ELEM_W + 1 + FRAC_BITS;
	localparam int QB = 17;
	localparam int DW = ((NW > DV + QB) ? NW : DV + QB) + 1;
	localparam logic signed [AW:0] ONE_A = {{(AW - FRAC_BITS){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

	typedef struct packed {
		rmq_pkg::branch_t br;
		logic [2:0]       neg;
		logic [2:0][16:0] mag;
	} side_t;

	function automatic logic signed [16:0] nterm(rmq_pkg::elem_t a, rmq_pkg::elem_t b,
			logic sub);
		logic signed [16:0] r;
		if (sub) begin
			r = 17'(a) - 17'(b);
		end else begin
			r = 17'(a) + 17'(b);
		end
		return r;
	endfunction

	function automatic rmq_pkg::elem_t lane_sat(logic [QB-1:0] q, logic ovf, logic zero,
			logic neg);
		logic [QB-1:0] qc;
		logic [QB-1:0] qn;
		rmq_pkg::elem_t r;
		if (zero) begin
			qc = '0;
		end else if (ovf || q > QB'(32768)) begin
			qc = QB'(32768);
		end else begin
			qc = q;
		end
		qn = -qc;
		if (neg) begin
			r = qn[15:0];
		end else if (qc > QB'(rmq_pkg::QMAX)) begin
			r = 16'(rmq_pkg::QMAX);
		end else begin
			r = qc[15:0];
		end
		return r;
	endfunction

	logic en;
	logic out_v_q;

	assign en        = !out_v_q || quat.ready;
	assign mat.ready = en;

	// stage 1: trace and branch choice
	logic signed [17:0] t_c;
	rmq_pkg::branch_t   br_c;
	logic               v_s1;
	rmq_pkg::elem_t     m_s1 [9];
	logic signed [17:0] t_s1;
	rmq_pkg::branch_t   br_s1;

	always_comb begin
		t_c = 18'(mat.r00) + 18'(mat.r11) + 18'(mat.r22);
		if (t_c > 18'sd0) begin
			br_c = rmq_pkg::BR_TRACE;
		end else if (mat.r00 > mat.r11 && mat.r00 > mat.r22) begin
			br_c = rmq_pkg::BR_X;
		end else if (mat.r11 > mat.r22) begin
			br_c = rmq_pkg::BR_Y;
		end else begin
			br_c = rmq_pkg::BR_Z;
		end
	end

	// stage 2 (root stage 0): square-root argument and numerators
	logic signed [AW:0] arg_c;
	logic [AW-1:0]      argu_c;
	logic signed [16:0] n_c [3];
	side_t              side_c;

	always_comb begin
		case (br_s1)
			rmq_pkg::BR_TRACE: begin
				arg_c  = ONE_A + (AW+1)'(t_s1);
				n_c[0] = nterm(m_s1[7], m_s1[5], 1'b1);
				n_c[1] = nterm(m_s1[2], m_s1[6], 1'b1);
				n_c[2] = nterm(m_s1[3], m_s1[1], 1'b1);
			end
			rmq_pkg::BR_X: begin
				arg_c  = ONE_A + (AW+1)'(m_s1[0]) - (AW+1)'(m_s1[4]) - (AW+1)'(m_s1[8]);
				n_c[0] = nterm(m_s1[7], m_s1[5], 1'b1);
				n_c[1] = nterm(m_s1[1], m_s1[3], 1'b0);
				n_c[2] = nterm(m_s1[2], m_s1[6], 1'b0);
			end
			rmq_pkg::BR_Y: begin
				arg_c  = ONE_A + (AW+1)'(m_s1[4]) - (AW+1)'(m_s1[0]) - (AW+1)'(m_s1[8]);
				n_c[0] = nterm(m_s1[2], m_s1[6], 1'b1);
				n_c[1] = nterm(m_s1[1], m_s1[3], 1'b0);
				n_c[2] = nterm(m_s1[5], m_s1[7], 1'b0);
			end
			default: begin
				arg_c  = ONE_A + (AW+1)'(m_s1[8]) - (AW+1)'(m_s1[0]) - (AW+1)'(m_s1[4]);
				n_c[0] = nterm(m_s1[3], m_s1[1], 1'b1);
				n_c[1] = nterm(m_s1[2], m_s1[6], 1'b0);
				n_c[2] = nterm(m_s1[5], m_s1[7], 1'b0);
			end
		endcase
		// negative argument clamps to zero
		argu_c = arg_c[AW] ? '0 : arg_c[AW-1:0];
		side_c.br = br_s1;
		for (int l = 0; l < 3; l++) begin
			side_c.neg[l] = n_c[l][16];
			// magnitude keeps 17 bits so that -65536 survives
			side_c.mag[l] = n_c[l][16] ? 17'(-n_c[l]) : 17'(n_c[l]);
		end
	end

	// square root, one result bit per stage; index 0 is stage 2
	logic              sq_v_s    [RW+1];
	logic [XW-1:0]     sq_x_s    [RW+1];
	logic [RM-1:0]     sq_rem_s  [RW+1];
	logic [RW-1:0]     sq_root_s [RW+1];
	side_t             sq_side_s [RW+1];
	logic [XW-1:0]     sq_x_c    [RW+1];
	logic [RM-1:0]     sq_rem_c  [RW+1];
	logic [RW-1:0]     sq_root_c [RW+1];
	logic [RM-1:0]     rem4_c    [RW+1];
	logic [RM-1:0]     trial_c   [RW+1];

	always_comb begin
		sq_x_c[0]    = XW'(argu_c) << FRAC_BITS;
		sq_rem_c[0]  = '0;
		sq_root_c[0] = '0;
		rem4_c[0]    = '0;
		trial_c[0]   = '0;
		for (int k = 1; k <= RW; k++) begin
			rem4_c[k]  = {sq_rem_s[k-1][RW:0], sq_x_s[k-1][XW-1 -: 2]};
			trial_c[k] = {1'b0, sq_root_s[k-1], 2'b01};
			sq_x_c[k]  = sq_x_s[k-1] << 2;
			if (rem4_c[k] >= trial_c[k]) begin
				sq_rem_c[k]  = rem4_c[k] - trial_c[k];
				sq_root_c[k] = {sq_root_s[k-1][RW-2:0], 1'b1};
			end else begin
				sq_rem_c[k]  = rem4_c[k];
				sq_root_c[k] = {sq_root_s[k-1][RW-2:0], 1'b0};
			end
		end
	end

	// dividers: stage 0 checks for quotient overflow, then one bit per stage
	logic              dv_v_s    [QB+1];
	logic [DV-1:0]     dv_d_s    [QB+1];
	logic [2:0][DW-1:0] dv_rem_s [QB+1];
	logic [2:0][QB-1:0] dv_q_s   [QB+1];
	logic [2:0]        dv_ovf_s  [QB+1];
	logic [2:0]        dv_zero_s [QB+1];
	side_t             dv_side_s [QB+1];
	logic [RW-2:0]     dv_half_s [QB+1];
	logic [DV-1:0]     d0_c;
	logic [2:0][DW-1:0] num_c;
	logic [2:0]        ovf0_c;
	logic [2:0]        zero0_c;
	logic [2:0][DW-1:0] dv_rem_c [QB+1];
	logic [2:0][QB-1:0] dv_q_c   [QB+1];
	logic [DW-1:0]     sh_c      [QB+1];

	always_comb begin
		d0_c = {sq_root_s[RW], 1'b0};
		for (int l = 0; l < 3; l++) begin
			num_c[l]   = DW'(sq_side_s[RW].mag[l]) << FRAC_BITS;
			ovf0_c[l]  = num_c[l] >= (DW'(d0_c) << QB);
			zero0_c[l] = sq_side_s[RW].mag[l] == 17'd0;
		end
		dv_rem_c[0] = num_c;
		dv_q_c[0]   = '0;
		sh_c[0]     = '0;
		for (int j = 1; j <= QB; j++) begin
			sh_c[j] = DW'(dv_d_s[j-1]) << (QB - j);
			for (int l = 0; l < 3; l++) begin
				if (dv_rem_s[j-1][l] >= sh_c[j]) begin
					dv_rem_c[j][l] = dv_rem_s[j-1][l] - sh_c[j];
					dv_q_c[j][l]   = {dv_q_s[j-1][l][QB-2:0], 1'b1};
				end else begin
					dv_rem_c[j][l] = dv_rem_s[j-1][l];
					dv_q_c[j][l]   = {dv_q_s[j-1][l][QB-2:0], 1'b0};
				end
			end
		end
	end

	// output stage: saturate and place the components
	rmq_pkg::elem_t   lane_c [3];
	rmq_pkg::elem_t   main_c;
	rmq_pkg::elem_t   w_c, x_c, y_c, z_c;
	rmq_pkg::elem_t   w_q, x_q, y_q, z_q;
	rmq_pkg::branch_t br_q;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			lane_c[l] = lane_sat(dv_q_s[QB][l], dv_ovf_s[QB][l], dv_zero_s[QB][l],
				dv_side_s[QB].neg[l]);
		end
		if (32'(dv_half_s[QB]) > 32'(rmq_pkg::QMAX)) begin
			main_c = 16'(rmq_pkg::QMAX);
		end else begin
			main_c = 16'(dv_half_s[QB]);
		end
		case (dv_side_s[QB].br)
			rmq_pkg::BR_TRACE: begin
				w_c = main_c;    x_c = lane_c[0]; y_c = lane_c[1]; z_c = lane_c[2];
			end
			rmq_pkg::BR_X: begin
				w_c = lane_c[0]; x_c = main_c;    y_c = lane_c[1]; z_c = lane_c[2];
			end
			rmq_pkg::BR_Y: begin
				w_c = lane_c[0]; x_c = lane_c[1]; y_c = main_c;    z_c = lane_c[2];
			end
			default: begin
				w_c = lane_c[0]; x_c = lane_c[1]; y_c = lane_c[2]; z_c = main_c;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
			for (int k = 0; k <= RW; k++) sq_v_s[k] <= 1'b0;
			for (int j = 0; j <= QB; j++) dv_v_s[j] <= 1'b0;
		end else if (en) begin
			v_s1      <= mat.valid;
			sq_v_s[0] <= v_s1;
			for (int k = 1; k <= RW; k++) sq_v_s[k] <= sq_v_s[k-1];
			dv_v_s[0] <= sq_v_s[RW];
			for (int j = 1; j <= QB; j++) dv_v_s[j] <= dv_v_s[j-1];
			out_v_q   <= dv_v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1[0] <= mat.r00; m_s1[1] <= mat.r01; m_s1[2] <= mat.r02;
			m_s1[3] <= mat.r10; m_s1[4] <= mat.r11; m_s1[5] <= mat.r12;
			m_s1[6] <= mat.r20; m_s1[7] <= mat.r21; m_s1[8] <= mat.r22;
			t_s1    <= t_c;
			br_s1   <= br_c;
			sq_side_s[0] <= side_c;
			for (int k = 0; k <= RW; k++) begin
				sq_x_s[k]    <= sq_x_c[k];
				sq_rem_s[k]  <= sq_rem_c[k];
				sq_root_s[k] <= sq_root_c[k];
			end
			for (int k = 1; k <= RW; k++) sq_side_s[k] <= sq_side_s[k-1];
			dv_d_s[0]    <= d0_c;
			dv_ovf_s[0]  <= ovf0_c;
			dv_zero_s[0] <= zero0_c;
			dv_side_s[0] <= sq_side_s[RW];
			dv_half_s[0] <= sq_root_s[RW][RW-1:1];
			for (int j = 0; j <= QB; j++) begin
				dv_rem_s[j] <= dv_rem_c[j];
				dv_q_s[j]   <= dv_q_c[j];
			end
			for (int j = 1; j <= QB; j++) begin
				dv_d_s[j]    <= dv_d_s[j-1];
				dv_ovf_s[j]  <= dv_ovf_s[j-1];
				dv_zero_s[j] <= dv_zero_s[j-1];
				dv_side_s[j] <= dv_side_s[j-1];
				dv_half_s[j] <= dv_half_s[j-1];
			end
			w_q  <= w_c;
			x_q  <= x_c;
			y_q  <= y_c;
			z_q  <= z_c;
			br_q <= dv_side_s[QB].br;
		end
	end

	assign quat.valid  = out_v_q;
	assign quat.quat_w = w_q;
	assign quat.quat_x = x_q;
	assign quat.quat_y = y_q;
	assign quat.quat_z = z_q;

	// a held pipe keeps its last divider stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> dv_v_s[QB] == $past(dv_v_s[QB]))
		else $error("divider stage changed during stall");

	// a request leaving stage 2 reaches the first root stage
	a_root_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && sq_v_s[0] |=> sq_v_s[1])
		else $error("request lost entering square root");

	// the square-root driven component is never negative
	a_main_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ((br_q == rmq_pkg::BR_TRACE && !w_q[15]) ||
			(br_q == rmq_pkg::BR_X && !x_q[15]) ||
			(br_q == rmq_pkg::BR_Y && !y_q[15]) ||
			(br_q == rmq_pkg::BR_Z && !z_q[15])))
		else $error("main component negative");

endmodule

>>> tb/tb_top.sv
// self-checking bench for rotation_matrix_to_quaternion_core: random and corner matrices,
// expected quaternions computed in-bench, random stalls on both channels
// depends on rmq_pkg, rmq_mat_if, rmq_quat_if and the core
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		rmq_pkg::elem_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
	} matrix_t;

	typedef struct packed {
		rmq_pkg::elem_t w, x, y, z;
	} quat_t;

	localparam int ONE = 1 << rmq_pkg::FRAC_BITS_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   n_errors = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;

	matrix_t matrix_q[$];
	quat_t   quat_expected_q[$];

	rmq_mat_if  mat ();
	rmq_quat_if quat ();

	rotation_matrix_to_quaternion_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.mat    (mat.sink),
		.quat   (quat.source)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned divisor_of(longint arg);
		if (arg <= 0) return 0;
		return 2 * root_floor(longint'(arg) << rmq_pkg::FRAC_BITS_DEF);
	endfunction

	function automatic rmq_pkg::elem_t ratio_of(longint n, longint unsigned d);
		longint unsigned mag, q;
		longint sq;
		if (d == 0) begin
			if (n > 0) return rmq_pkg::elem_t'(rmq_pkg::QMAX);
			if (n < 0) return rmq_pkg::elem_t'(-32768);
			return '0;
		end
		mag = (n < 0) ? -n : n;
		q = (mag << rmq_pkg::FRAC_BITS_DEF) / d;
		if (q > 32768) q = 32768;
		sq = (n < 0) ? -longint'(q) : longint'(q);
		if (sq > rmq_pkg::QMAX) sq = rmq_pkg::QMAX;
		return rmq_pkg::elem_t'(sq);
	endfunction

	function automatic rmq_pkg::elem_t main_of(longint unsigned d);
		longint unsigned v;
		v = d >> 2;
		if (v > rmq_pkg::QMAX) v = rmq_pkg::QMAX;
		return rmq_pkg::elem_t'(v);
	endfunction

	function automatic quat_t matrix_to_quat(matrix_t m);
		longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr;
		longint unsigned d;
		quat_t q;
		a00 = m.r00; a01 = m.r01; a02 = m.r02;
		a10 = m.r10; a11 = m.r11; a12 = m.r12;
		a20 = m.r20; a21 = m.r21; a22 = m.r22;
		tr = a00 + a11 + a22;
		if (tr > 0) begin
			d = divisor_of(tr + ONE);
			q.w = main_of(d);
			q.x = ratio_of(a21 - a12, d);
			q.y = ratio_of(a02 - a20, d);
			q.z = ratio_of(a10 - a01, d);
		end else if (a00 > a11 && a00 > a22) begin
			d = divisor_of(ONE + a00 - a11 - a22);
			q.w = ratio_of(a21 - a12, d);
			q.x = main_of(d);
			q.y = ratio_of(a01 + a10, d);
			q.z = ratio_of(a02 + a20, d);
		end else if (a11 > a22) begin
			d = divisor_of(ONE + a11 - a00 - a22);
			q.w = ratio_of(a02 - a20, d);
			q.x = ratio_of(a01 + a10, d);
			q.y = main_of(d);
			q.z = ratio_of(a12 + a21, d);
		end else begin
			d = divisor_of(ONE + a22 - a00 - a11);
			q.w = ratio_of(a10 - a01, d);
			q.x = ratio_of(a02 + a20, d);
			q.y = ratio_of(a12 + a21, d);
			q.z = main_of(d);
		end
		return q;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch %s", msg);
		n_errors++;
	endtask

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic rmq_pkg::elem_t rand_elem();
		int p;
		p = $urandom_range(0, 9);
		if (p < 6) return rmq_pkg::elem_t'($urandom_range(0, 2 * ONE) - ONE);
		if (p < 8) return rmq_pkg::elem_t'($urandom);
		case ($urandom_range(0, 3))
			0: return rmq_pkg::elem_t'(16'sh7fff);
			1: return rmq_pkg::elem_t'(16'sh8000);
			2: return rmq_pkg::elem_t'(ONE);
			default: return rmq_pkg::elem_t'(0);
		endcase
	endfunction

	// near-rotation: signed permutation matrices with small random noise
	function automatic matrix_t rand_rotation();
		rmq_pkg::elem_t e[9];
		int perm[3], sgn, i, j, tmp;
		perm = '{0, 1, 2};
		for (i = 2; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
		end
		for (i = 0; i < 9; i++) e[i] = rmq_pkg::elem_t'($urandom_range(0, 4000) - 2000);
		for (i = 0; i < 3; i++) begin
			sgn = $urandom_range(0, 1) ? 1 : -1;
			e[3 * i + perm[i]] = rmq_pkg::elem_t'(sgn * (ONE - int'($urandom_range(0, 3000))));
		end
		return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
	endfunction

	function automatic matrix_t rand_matrix();
		matrix_t m;
		if ($urandom_range(0, 9) < 7) return rand_rotation();
		m.r00 = rand_elem(); m.r01 = rand_elem(); m.r02 = rand_elem();
		m.r10 = rand_elem(); m.r11 = rand_elem(); m.r12 = rand_elem();
		m.r20 = rand_elem(); m.r21 = rand_elem(); m.r22 = rand_elem();
		return m;
	endfunction

	// driver
	int src_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat.valid <= 1'b0;
			{mat.r00, mat.r01, mat.r02, mat.r10, mat.r11, mat.r12,
				mat.r20, mat.r21, mat.r22} <= '0;
			src_gap <= 0;
		end else if (!mat.valid || mat.ready) begin
			if (mat.valid) quat_expected_q.push_back(matrix_to_quat(
				{mat.r00, mat.r01, mat.r02, mat.r10, mat.r11, mat.r12,
				mat.r20, mat.r21, mat.r22}));
			if (src_gap > 0 || matrix_q.size() == 0) begin
				mat.valid <= 1'b0;
				if (src_gap > 0) src_gap <= src_gap - 1;
			end else begin
				matrix_t m;
				m = matrix_q.pop_front();
				{mat.r00, mat.r01, mat.r02, mat.r10, mat.r11, mat.r12,
					mat.r20, mat.r21, mat.r22} <= m;
				mat.valid <= 1'b1;
				src_gap <= gap_len();
			end
		end
	end

	// monitor and receiver stalls
	int snk_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat.ready <= 1'b0;
			snk_gap <= 0;
		end else begin
			if (quat.valid && quat.ready) begin
				if (quat_expected_q.size() == 0) begin
					report_mismatch("quaternion with no request pending");
				end else begin
					quat_t want;
					want = quat_expected_q.pop_front();
					if (quat.quat_w !== want.w) report_mismatch($sformatf(
						"w: got %0d expected %0d", quat.quat_w, want.w));
					if (quat.quat_x !== want.x) report_mismatch($sformatf(
						"x: got %0d expected %0d", quat.quat_x, want.x));
					if (quat.quat_y !== want.y) report_mismatch($sformatf(
						"y: got %0d expected %0d", quat.quat_y, want.y));
					if (quat.quat_z !== want.z) report_mismatch($sformatf(
						"z: got %0d expected %0d", quat.quat_z, want.z));
				end
			end
			if (hold_left > 0) begin
				quat.ready <= 1'b0;
			end else if (snk_gap > 0) begin
				quat.ready <= 1'b0;
				snk_gap <= snk_gap - 1;
			end else begin
				quat.ready <= 1'b1;
				snk_gap <= gap_len();
			end
		end
	end

	// long receiver hold-off so the pipe fills and backs up
	always @(posedge clk) begin
		if (arst_n && !hold_done && matrix_q.size() < 1300) begin
			hold_left <= 200;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	initial begin
		matrix_t m;
		rmq_pkg::elem_t corner[4];
		corner = '{rmq_pkg::elem_t'(16'sh7fff), rmq_pkg::elem_t'(16'sh8000),
			rmq_pkg::elem_t'(0), rmq_pkg::elem_t'(ONE)};
		// identity, trace branch
		matrix_q.push_back({rmq_pkg::elem_t'(ONE), 16'sd0, 16'sd0, 16'sd0,
			rmq_pkg::elem_t'(ONE), 16'sd0, 16'sd0, 16'sd0, rmq_pkg::elem_t'(ONE)});
		// x, y and z dominant diagonals
		matrix_q.push_back({rmq_pkg::elem_t'(ONE), 16'sd0, 16'sd0, 16'sd0,
			rmq_pkg::elem_t'(-ONE), 16'sd0, 16'sd0, 16'sd0, rmq_pkg::elem_t'(-ONE)});
		matrix_q.push_back({rmq_pkg::elem_t'(-ONE), 16'sd0, 16'sd0, 16'sd0,
			rmq_pkg::elem_t'(ONE), 16'sd0, 16'sd0, 16'sd0, rmq_pkg::elem_t'(-ONE)});
		matrix_q.push_back({rmq_pkg::elem_t'(-ONE), 16'sd0, 16'sd0, 16'sd0,
			rmq_pkg::elem_t'(-ONE), 16'sd0, 16'sd0, 16'sd0, rmq_pkg::elem_t'(ONE)});
		// ties on the diagonal with non-positive trace
		matrix_q.push_back({rmq_pkg::elem_t'(-100), 16'sd5, 16'sd7, 16'sd9,
			rmq_pkg::elem_t'(-100), 16'sd3, 16'sd2, 16'sd1, rmq_pkg::elem_t'(-100)});
		matrix_q.push_back({rmq_pkg::elem_t'(0), 16'sd50, -16'sd50, 16'sd40,
			rmq_pkg::elem_t'(0), 16'sd30, 16'sd20, -16'sd10, rmq_pkg::elem_t'(-9)});
		// most negative diagonal (z branch by tie), with negative and with zero numerators
		matrix_q.push_back({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff,
			16'sh7fff, 16'sh8000, 16'sh8000});
		matrix_q.push_back({16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sd0,
			16'sd0, 16'sd0, 16'sh8000});
		// uniform matrices: all max, all min, all zero and all minus one
		matrix_q.push_back({9{16'sh7fff}});
		matrix_q.push_back({9{16'sh8000}});
		matrix_q.push_back({9{16'sh0000}});
		matrix_q.push_back({9{16'shffff}});
		// tiny positive trace: trace branch with full-scale negative quotients
		matrix_q.push_back({16'sd1, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sd0, 16'sh7fff,
			16'sh7fff, 16'sh8000, 16'sd0});
		for (int i = 0; i < 10; i++) begin
			m = {corner[$urandom_range(0, 3)], corner[$urandom_range(0, 3)],
				corner[$urandom_range(0, 3)], corner[$urandom_range(0, 3)],
				corner[$urandom_range(0, 3)], corner[$urandom_range(0, 3)],
				corner[$urandom_range(0, 3)], corner[$urandom_range(0, 3)],
				corner[$urandom_range(0, 3)]};
			matrix_q.push_back(m);
		end
		for (int i = 0; i < 1450; i++) matrix_q.push_back(rand_matrix());

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (matrix_q.size() == 0);
		@(posedge clk);
		while (mat.valid) @(posedge clk);
		while (quat_expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (n_errors == 0) begin
			$display("** rotation_matrix_to_quaternion_core: PASSED **");
		end else begin
			$display("** rotation_matrix_to_quaternion_core: FAILED **");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("** rotation_matrix_to_quaternion_core: FAILED **");
		$finish;
	end
endmodule

>>> sim.f
design/rmq_pkg.sv
design/rmq_mat_if.sv
design/rmq_quat_if.sv
design/rotation_matrix_to_quaternion_core.sv
tb/tb_top.sv
